// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cdfis_pkg.sv =====
package cdfis_pkg;

    localparam int CDF_W = 16;   // Q0.16 entries and random numbers
    localparam int IDX_W = 8;    // row / column index
    localparam int CNT_W = 9;    // count, 0..256

    // search unit control: clear bounds, or take one bisection step
    typedef struct packed {
        logic load;
        logic step;
    } t_srch_ctrl;

    // search unit status, values after the current cycle's update
    typedef struct packed {
        logic             next_active;  // bounds still enclose entries
        logic [IDX_W-1:0] next_mid;     // next entry to fetch
        logic             found;
        logic [IDX_W-1:0] idx;          // lowest qualifying index so far
        logic [CDF_W-1:0] cur;          // entry at idx
    } t_srch_stat;

endpackage

// ===== rtl/core/cdfis_ram.sv =====
module cdfis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cdfis_search.sv =====
module cdfis_search
    import cdfis_pkg::*;
(
    input  logic             i_clk,
    input  t_srch_ctrl       i_ctrl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CDF_W-1:0] i_key,
    input  logic [CDF_W-1:0] i_data,   // entry at the current mid
    output t_srch_stat       o_stat
);

    // bounds are [low, hi): hi is one past the last candidate
    logic [CNT_W-1:0] r_low, n_low;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CDF_W-1:0] r_cur, n_cur;

    logic [CNT_W:0]   msum;
    logic [CNT_W:0]   n_msum;
    logic [IDX_W-1:0] mid;

    assign msum = {1'b0, r_low} + {1'b0, r_hi} - (CNT_W+1)'(1);
    assign mid  = msum[IDX_W:1];

    always_comb begin
        n_low   = r_low;
        n_hi    = r_hi;
        n_found = r_found;
        n_idx   = r_idx;
        n_cur   = r_cur;
        if (i_ctrl.load) begin
            n_low   = '0;
            n_hi    = i_count;
            n_found = 1'b0;
            n_idx   = '0;
            n_cur   = '0;
        end else if (i_ctrl.step) begin
            if (i_data >= i_key) begin
                n_found = 1'b1;
                n_idx   = mid;
                n_cur   = i_data;
                n_hi    = {1'b0, mid};
            end else begin
                n_low = {1'b0, mid} + CNT_W'(1);
            end
        end
    end

    assign n_msum = {1'b0, n_low} + {1'b0, n_hi} - (CNT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_hi    <= n_hi;
        r_found <= n_found;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
    end

    always_comb begin
        o_stat.next_active = (n_low < n_hi);
        o_stat.next_mid    = n_msum[IDX_W:1];
        o_stat.found       = n_found;
        o_stat.idx         = n_idx;
        o_stat.cur         = n_cur;
    end

endmodule

// ===== rtl/core/cdf_table_inverse_sampler_top.sv =====
// Two-level inverse-CDF sampler over a piecewise-constant 2D table.
//
// Input channel: a word is taken at a rising edge with start high and busy
// low. Command 0 writes a marginal entry at row, command 1 writes the
// conditional entry (row, column); both take effect when taken and give
// no result, so busy stays low. Command 2 samples with random_row and
// random_column; command 3 is dropped.
// A sample raises busy for a load state, the bisection steps (one registered
// store read each) and, where the found index is above zero, a predecessor
// read per table, marginal then conditional. The result is strobed in the
// next cycle, so a new sample is taken only after the last one is through.
// Result channel: o_strobe is high for exactly one cycle with the fields;
// the receiver cannot stall, and busy is already low in that cycle.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 row_count, 1 column_count) at once; write only while idle.
// Reset (synchronous, active low) sets both counts to 256 and returns the
// sequencer to idle; table contents are left as they are.
module cdf_table_inverse_sampler_top
    import cdfis_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_row,
    input  logic [7:0]       i_column,
    input  logic [15:0]      i_cdf_value,
    input  logic [15:0]      i_random_row,
    input  logic [15:0]      i_random_column,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [8:0]       i_cfg_wdata,
    output logic             o_strobe,
    output logic [7:0]       o_row_index,
    output logic [7:0]       o_column_index,
    output logic [15:0]      o_row_probability,
    output logic [15:0]      o_column_probability,
    output logic             o_not_found
);

    `include "assert_macros.svh"

    localparam int RAW   = $clog2(MAX_ROWS);
    localparam int CDEP  = MAX_ROWS * MAX_COLUMNS;
    localparam int CAW   = $clog2(CDEP);
    localparam logic [CNT_W-1:0] ROW_LIM = CNT_W'((MAX_ROWS < 256) ? MAX_ROWS : 256);
    localparam logic [CNT_W-1:0] COL_LIM = CNT_W'((MAX_COLUMNS < 256) ? MAX_COLUMNS : 256);
    localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(256);

    typedef enum logic [1:0] {
        CMD_WR_MARGINAL    = 2'd0,
        CMD_WR_CONDITIONAL = 2'd1,
        CMD_SAMPLE         = 2'd2
    } t_cmd;

    typedef enum logic {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        PH_MARGINAL    = 1'b0,
        PH_CONDITIONAL = 1'b1
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,   // set search bounds, fetch first mid
        ST_SRCH = 4'b0100,   // one bisection step per cycle
        ST_PREV = 4'b1000    // predecessor entry arrives
    } t_state;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_row_count, r_column_count;
    logic [CDF_W-1:0] r_rnd_row, r_rnd_col;
    logic [IDX_W-1:0] r_row_sel, n_row_sel;
    logic [CDF_W-1:0] r_row_prob, n_row_prob;

    logic             r_strobe, n_strobe;
    logic [IDX_W-1:0] r_row_index, n_row_index;
    logic [IDX_W-1:0] r_column_index, n_column_index;
    logic [CDF_W-1:0] r_row_probability, n_row_probability;
    logic [CDF_W-1:0] r_column_probability, n_column_probability;
    logic             r_not_found, n_not_found;

    logic             accept;
    logic             mar_we, con_we;
    logic [RAW-1:0]   mar_waddr, mar_raddr;
    logic [CAW-1:0]   con_waddr, con_raddr;
    logic [CDF_W-1:0] mar_rdata, con_rdata, rdata;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] eff_rows, eff_cols;

    t_srch_ctrl       srch_ctrl;
    t_srch_stat       srch_stat;

    logic             done_ok, done_fail;
    logic [CDF_W-1:0] done_prob;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // ---- config registers, counts saturated to table size ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= COUNT_RST;
            r_column_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:    r_row_count    <= i_cfg_wdata;
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_rows = (r_row_count > ROW_LIM) ? ROW_LIM : r_row_count;
    assign eff_cols = (r_column_count > COL_LIM) ? COL_LIM : r_column_count;

    // ---- table writes, out-of-range rows / columns dropped ----
    assign mar_we = accept && (i_command == CMD_WR_MARGINAL)
                    && (32'(i_row) < 32'(MAX_ROWS));
    assign con_we = accept && (i_command == CMD_WR_CONDITIONAL)
                    && (32'(i_row) < 32'(MAX_ROWS))
                    && (32'(i_column) < 32'(MAX_COLUMNS));
    assign mar_waddr = RAW'(i_row);
    assign con_waddr = CAW'(32'(i_row) * 32'(MAX_COLUMNS) + 32'(i_column));

    // ---- table reads: both stores share the search index ----
    assign mar_raddr = RAW'(rd_idx);
    assign con_raddr = CAW'(32'(r_row_sel) * 32'(MAX_COLUMNS) + 32'(rd_idx));
    assign rdata     = (r_phase == PH_CONDITIONAL) ? con_rdata : mar_rdata;

    cdfis_ram #(
        .WIDTH (CDF_W),
        .DEPTH (MAX_ROWS)
    ) u_marginal (
        .i_clk   (i_clk),
        .i_we    (mar_we),
        .i_waddr (mar_waddr),
        .i_wdata (i_cdf_value),
        .i_raddr (mar_raddr),
        .o_rdata (mar_rdata)
    );

    cdfis_ram #(
        .WIDTH (CDF_W),
        .DEPTH (CDEP)
    ) u_conditional (
        .i_clk   (i_clk),
        .i_we    (con_we),
        .i_waddr (con_waddr),
        .i_wdata (i_cdf_value),
        .i_raddr (con_raddr),
        .o_rdata (con_rdata)
    );

    // ---- shared bisection unit ----
    cdfis_search u_search (
        .i_clk   (i_clk),
        .i_ctrl  (srch_ctrl),
        .i_count ((r_phase == PH_CONDITIONAL) ? eff_cols : eff_rows),
        .i_key   ((r_phase == PH_CONDITIONAL) ? r_rnd_col : r_rnd_row),
        .i_data  (rdata),
        .o_stat  (srch_stat)
    );

    // random numbers held for the whole sample
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rnd_row <= i_random_row;
            r_rnd_col <= i_random_column;
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state              = r_state;
        n_phase              = r_phase;
        n_row_sel            = r_row_sel;
        n_row_prob           = r_row_prob;
        n_strobe             = 1'b0;
        n_row_index          = r_row_index;
        n_column_index       = r_column_index;
        n_row_probability    = r_row_probability;
        n_column_probability = r_column_probability;
        n_not_found          = r_not_found;
        srch_ctrl            = '0;
        rd_idx               = srch_stat.next_mid;
        done_ok              = 1'b0;
        done_fail            = 1'b0;
        done_prob            = srch_stat.cur;

        case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_SAMPLE)) begin
                    n_state = ST_LOAD;
                    n_phase = PH_MARGINAL;
                end
            end
            ST_LOAD: begin
                srch_ctrl.load = 1'b1;
                if (!srch_stat.next_active) begin
                    done_fail = 1'b1;   // empty count
                end else begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                srch_ctrl.step = 1'b1;
                if (!srch_stat.next_active) begin
                    if (!srch_stat.found) begin
                        done_fail = 1'b1;
                    end else if (srch_stat.idx == '0) begin
                        done_ok = 1'b1; // no predecessor: entry is the probability
                    end else begin
                        rd_idx  = srch_stat.idx - IDX_W'(1);
                        n_state = ST_PREV;
                    end
                end
            end
            ST_PREV: begin
                done_ok   = 1'b1;
                done_prob = (srch_stat.cur >= rdata) ? (srch_stat.cur - rdata) : '0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (done_fail) begin
            n_state              = ST_IDLE;
            n_strobe             = 1'b1;
            n_row_index          = '0;
            n_column_index       = '0;
            n_row_probability    = '0;
            n_column_probability = '0;
            n_not_found          = 1'b1;
        end else if (done_ok) begin
            if (r_phase == PH_MARGINAL) begin
                n_row_sel  = srch_stat.idx;
                n_row_prob = done_prob;
                n_phase    = PH_CONDITIONAL;
                n_state    = ST_LOAD;
            end else begin
                n_state              = ST_IDLE;
                n_strobe             = 1'b1;
                n_row_index          = r_row_sel;
                n_column_index       = srch_stat.idx;
                n_row_probability    = r_row_prob;
                n_column_probability = done_prob;
                n_not_found          = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_MARGINAL;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_sel            <= n_row_sel;
        r_row_prob           <= n_row_prob;
        r_row_index          <= n_row_index;
        r_column_index       <= n_column_index;
        r_row_probability    <= n_row_probability;
        r_column_probability <= n_column_probability;
        r_not_found          <= n_not_found;
    end

    assign o_strobe             = r_strobe;
    assign o_row_index          = r_row_index;
    assign o_column_index       = r_column_index;
    assign o_row_probability    = r_row_probability;
    assign o_column_probability = r_column_probability;
    assign o_not_found          = r_not_found;

    // ---- checks ----
    `ASSERT_IMPLY(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, accept && (i_command == CMD_SAMPLE), busy)
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_strobe && o_not_found,
                  (o_row_index == '0) && (o_column_index == '0)
                  && (o_row_probability == '0) && (o_column_probability == '0))

endmodule
